// ----- hdl/rrp_pkg.sv -----
// Shared types and constants of the reply parser: phases, token kinds,
// status codes, item structs and character codes. No dependencies.
`default_nettype none

package rrp_pkg;

  localparam int MaxDepthDef   = 128;
  localparam int LengthBitsDef = 32;

  // Parse phases
  typedef enum logic [3:0] {
    PH_TYPE, PH_SIMPLE, PH_INT, PH_BLEN, PH_ALEN, PH_NUMBAD, PH_BDATA,
    PH_BCR, PH_BLF, PH_ERRMSG, PH_ERRDONE, PH_DONE, PH_FAULT
  } phase_e;

  // Token kinds
  typedef enum logic [2:0] {
    K_TEXT, K_SIMPLE_END, K_BULK_END, K_INT, K_NULL, K_ARRAY, K_ERR_BYTE, K_STATUS
  } kind_e;

  // Final status codes
  typedef enum logic [3:0] {
    ST_OK, ST_ERR_REPLY, ST_INVALID, ST_TRUNC_LINE, ST_BAD_LEN, ST_BAD_BULK_LEN,
    ST_TRUNC_BULK, ST_BAD_ARR_LEN, ST_BAD_TYPE, ST_TRAILING
  } status_e;

  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       no_byte;
    logic       end_of_reply;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         token_kind;
    logic [7:0]         payload_byte;
    logic signed [63:0] int_value;
    logic [7:0]         nest_level_out;
    logic [3:0]         final_status;
    logic               run_last;
  } out_item_t;

  // Results written into the output queue in the same cycle
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

  // Stack entry: remaining element count and the level a close falls back to
  typedef struct packed {
    logic [30:0] cnt;
    logic [7:0]  fall;
  } stack_ent_t;

endpackage

`default_nettype wire

// ----- hdl/rrp_if.sv -----
// Valid/ready channel interfaces for reply bytes and tokens.
// Depends on rrp_pkg.
`default_nettype none

interface rrp_in_if import rrp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrp_out_if import rrp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/rrp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/rrp_out_fifo.sv -----
// Four-entry token queue: takes up to two items a cycle, gives one when ready.
// Depends on rrp_pkg and rrp_out_if.
`default_nettype none

module rrp_out_fifo import rrp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       space_o,
  rrp_out_if.source  out_o
);

  localparam int Depth = 4;

  out_item_t  mem_q [Depth];
  logic [1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign pop         = out_o.valid && out_o.ready;
  assign out_o.valid = (count_q != 3'd0);
  assign out_o.data  = mem_q[rptr_q];
  assign space_o     = (count_q <= 3'd2);

  // Advance pointers and count
  always_comb begin
    wptr_d  = wptr_q + push_i.cnt;
    rptr_d  = rptr_q + {1'b0, pop};
    count_d = count_q + {1'b0, push_i.cnt} - {2'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store items
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wptr_q] <= push_i.item0;
    if (push_i.cnt == 2'd2) mem_q[wptr_q + 2'd1] <= push_i.item1;
  end

endmodule

`default_nettype wire

// ----- hdl/resp_reply_parser.sv -----
// Reply parser top level. Tokens are registered in the token queue on the way to
// the output. One byte a cycle is taken while the four-entry token queue has
// two free slots; a byte that gives two tokens writes both into the queue together.
// Top count in registers, the rest in one stack RAM; closing arrays costs one RAM read.
// Reset is asynchronous and clears all control state; the stack RAM is not cleared.
// Depends on rrp_pkg, rrp_if, rrp_ram and rrp_out_fifo.
`default_nettype none

module resp_reply_parser import rrp_pkg::*; #(
  parameter int MAX_DEPTH   = MaxDepthDef,
  parameter int LENGTH_BITS = LengthBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rrp_in_if.sink    in_i,
  rrp_out_if.source out_o
);

  localparam int AW = $clog2(MAX_DEPTH + 1);

  phase_e                 phase_q, phase_d;
  logic [7:0]             level_q, level_d;
  logic [63:0]            acc_q, acc_d;
  logic                   minus_q, minus_d;
  logic                   digit_q, digit_d;
  logic [LENGTH_BITS-1:0] brem_q, brem_d;
  logic                   held_q, held_d;
  status_e                fault_q, fault_d;
  logic [30:0]            top_cnt_q, top_cnt_d;
  logic [7:0]             top_fb_q, top_fb_d;
  logic                   load_q, load_d;

  logic          accept;
  logic          space;
  push_t         push;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  stack_ent_t    wr_data, rd_data;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = space;

  rrp_ram #(
    .WIDTH ($bits(stack_ent_t)),
    .DEPTH (MAX_DEPTH + 1)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  rrp_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

  function automatic out_item_t mk(input logic [2:0] kind, input logic [7:0] pay,
                                   input logic [63:0] val, input logic [7:0] lvl);
    out_item_t it;
    it.token_kind     = kind;
    it.payload_byte   = pay;
    it.int_value      = val;
    it.nest_level_out = lvl;
    it.final_status   = ST_OK;
    it.run_last       = 1'b0;
    return it;
  endfunction

  // Step one item: parse the byte, update the stack and build tokens
  always_comb begin : step
    logic [7:0]  b;
    logic        take;
    logic        neg;
    logic [63:0] nval;
    logic [63:0] acc10;
    logic [63:0] limit;
    logic [1:0]  en;
    out_item_t   e0, e1, st;
    logic        do_fin, do_push;
    logic [7:0]  fall;
    status_e     status;
    logic [7:0]  carry;

    b      = in_i.data.byte_in;
    take   = accept && !in_i.data.no_byte;
    neg    = minus_q && (acc_q != 64'd0);
    nval   = neg ? (64'd0 - acc_q) : acc_q;
    acc10  = (acc_q << 3) + (acc_q << 1) + {60'd0, b[3:0]};
    limit  = minus_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    en     = 2'd0;
    e0     = '0;
    e1     = '0;
    st     = '0;
    do_fin = 1'b0;
    do_push = 1'b0;
    fall   = (level_q == 8'd0) ? 8'd0 : top_fb_q;
    status = ST_OK;
    carry  = 8'd0;

    phase_d   = phase_q;
    level_d   = level_q;
    acc_d     = acc_q;
    minus_d   = minus_q;
    digit_d   = digit_q;
    brem_d    = brem_q;
    held_d    = held_q;
    fault_d   = fault_q;
    load_d    = 1'b0;
    top_cnt_d = load_q ? (rd_data.cnt - 31'd1) : top_cnt_q;
    top_fb_d  = load_q ? rd_data.fall : top_fb_q;
    wr_en     = 1'b0;
    wr_addr   = AW'(level_q - 8'd1);
    wr_data   = '{cnt: top_cnt_q, fall: top_fb_q};
    rd_en     = 1'b0;
    rd_addr   = AW'(fall - 8'd1);

    if (take) begin
      unique case (phase_q)
        PH_TYPE: begin
          priority if (b == ChPlus) begin
            held_d  = 1'b0;
            phase_d = PH_SIMPLE;
          end else if (b == ChColon || b == ChDollar || b == ChStar) begin
            acc_d   = '0;
            minus_d = 1'b0;
            digit_d = 1'b0;
            held_d  = 1'b0;
            phase_d = (b == ChColon) ? PH_INT : ((b == ChDollar) ? PH_BLEN : PH_ALEN);
          end else if (b == ChMinus && level_q == 8'd0) begin
            held_d  = 1'b0;
            phase_d = PH_ERRMSG;
          end else begin
            fault_d = ST_BAD_TYPE;
            phase_d = PH_FAULT;
            held_d  = 1'b0;
          end
        end
        PH_SIMPLE, PH_ERRMSG: begin
          if (held_q && b == ChLf) begin
            held_d = 1'b0;
            if (phase_q == PH_SIMPLE) begin
              e0     = mk(K_SIMPLE_END, 8'd0, 64'd0, level_q);
              en     = 2'd1;
              do_fin = 1'b1;
            end else begin
              phase_d = PH_ERRDONE;
            end
          end else begin
            // Flush a held CR as a text or error byte, then take the byte
            if (held_q) begin
              e0 = mk((phase_q == PH_SIMPLE) ? K_TEXT : K_ERR_BYTE, ChCr, 64'd0, level_q);
              en = 2'd1;
            end
            if (b == ChCr) begin
              held_d = 1'b1;
            end else begin
              held_d = 1'b0;
              if (en == 2'd0) begin
                e0 = mk((phase_q == PH_SIMPLE) ? K_TEXT : K_ERR_BYTE, b, 64'd0, level_q);
              end else begin
                e1 = mk((phase_q == PH_SIMPLE) ? K_TEXT : K_ERR_BYTE, b, 64'd0, level_q);
              end
              en = en + 2'd1;
            end
          end
        end
        PH_INT, PH_BLEN, PH_ALEN: begin
          priority if (held_q) begin
            held_d = 1'b0;
            if (b == ChLf) begin
              // Close the number line
              if (!digit_q) begin
                fault_d = ST_BAD_LEN;
                phase_d = PH_FAULT;
              end else if (phase_q == PH_INT) begin
                e0     = mk(K_INT, 8'd0, nval, level_q);
                en     = 2'd1;
                do_fin = 1'b1;
              end else if (neg) begin
                if (acc_q == 64'd1) begin
                  e0     = mk(K_NULL, 8'd0, 64'd0, level_q);
                  en     = 2'd1;
                  do_fin = 1'b1;
                end else begin
                  fault_d = (phase_q == PH_BLEN) ? ST_BAD_BULK_LEN : ST_BAD_ARR_LEN;
                  phase_d = PH_FAULT;
                end
              end else if (phase_q == PH_BLEN) begin
                if (acc_q[63:LENGTH_BITS] != '0) begin
                  fault_d = ST_BAD_BULK_LEN;
                  phase_d = PH_FAULT;
                end else begin
                  brem_d  = acc_q[LENGTH_BITS-1:0];
                  phase_d = (acc_q != 64'd0) ? PH_BDATA : PH_BCR;
                end
              end else if (acc_q > 64'h7FFF_FFFF) begin
                fault_d = ST_BAD_ARR_LEN;
                phase_d = PH_FAULT;
              end else begin
                e0 = mk(K_ARRAY, 8'd0, acc_q, level_q);
                en = 2'd1;
                if (acc_q == 64'd0) begin
                  do_fin = 1'b1;
                end else if (level_q >= 8'(MAX_DEPTH)) begin
                  fault_d = ST_INVALID;
                  phase_d = PH_FAULT;
                end else begin
                  do_push = 1'b1;
                end
              end
            end else begin
              phase_d = PH_NUMBAD;
              held_d  = (b == ChCr);
            end
          end else if (b == ChCr) begin
            held_d = 1'b1;
          end else if (b == ChMinus && !minus_q && !digit_q) begin
            minus_d = 1'b1;
          end else if (b >= ChZero && b <= ChNine) begin
            if (acc_q > 64'd922337203685477580 || acc10 > limit) begin
              phase_d = PH_NUMBAD;
            end else begin
              acc_d   = acc10;
              digit_d = 1'b1;
            end
          end else begin
            phase_d = PH_NUMBAD;
          end
        end
        PH_NUMBAD: begin
          if (held_q && b == ChLf) begin
            fault_d = ST_BAD_LEN;
            phase_d = PH_FAULT;
            held_d  = 1'b0;
          end else begin
            held_d = (b == ChCr);
          end
        end
        PH_BDATA: begin
          e0     = mk(K_TEXT, b, 64'd0, level_q);
          en     = 2'd1;
          brem_d = brem_q - LENGTH_BITS'(1);
          if (brem_q == LENGTH_BITS'(1)) phase_d = PH_BCR;
        end
        PH_BCR: begin
          if (b == ChCr) begin
            phase_d = PH_BLF;
          end else begin
            fault_d = ST_TRUNC_BULK;
            phase_d = PH_FAULT;
            held_d  = 1'b0;
          end
        end
        PH_BLF: begin
          if (b == ChLf) begin
            e0     = mk(K_BULK_END, 8'd0, 64'd0, level_q);
            en     = 2'd1;
            do_fin = 1'b1;
          end else begin
            fault_d = ST_TRUNC_BULK;
            phase_d = PH_FAULT;
            held_d  = 1'b0;
          end
        end
        PH_DONE: begin
          fault_d = ST_TRAILING;
          phase_d = PH_FAULT;
          held_d  = 1'b0;
        end
        default: ;
      endcase
    end

    // Close a value: count down the top array or pop finished arrays
    if (do_fin) begin
      if (level_q != 8'd0 && top_cnt_q > 31'd1) begin
        top_cnt_d = top_cnt_q - 31'd1;
        phase_d   = PH_TYPE;
      end else if (fall == 8'd0) begin
        level_d = 8'd0;
        phase_d = PH_DONE;
      end else begin
        level_d = fall;
        rd_en   = 1'b1;
        load_d  = 1'b1;
        phase_d = PH_TYPE;
      end
    end

    // Open an array: spill the top entry, keep the new one in registers
    if (do_push) begin
      wr_en     = (level_q != 8'd0);
      top_cnt_d = acc_q[30:0];
      top_fb_d  = (level_q == 8'd0) ? 8'd0 : ((top_cnt_q > 31'd1) ? level_q : top_fb_q);
      level_d   = level_q + 8'd1;
      phase_d   = PH_TYPE;
    end

    // End of reply: add the status item and start afresh
    if (accept && in_i.data.end_of_reply) begin
      if (phase_d == PH_ERRMSG && held_d) begin
        if (en == 2'd0) e0 = mk(K_ERR_BYTE, ChCr, 64'd0, level_q);
        else            e1 = mk(K_ERR_BYTE, ChCr, 64'd0, level_q);
        en = en + 2'd1;
      end
      if (fault_d != ST_OK) begin
        status = fault_d;
      end else begin
        unique case (phase_d)
          PH_ERRMSG, PH_ERRDONE: status = ST_ERR_REPLY;
          PH_DONE:               status = ST_OK;
          PH_TYPE:               status = ST_INVALID;
          PH_BDATA:              status = ST_BAD_BULK_LEN;
          PH_BCR, PH_BLF:        status = ST_TRUNC_BULK;
          default:               status = ST_TRUNC_LINE;
        endcase
      end
      if (status >= ST_INVALID) en = 2'd0;
      if (en == 2'd2) begin
        carry = e1.payload_byte;
        en    = 2'd1;
      end
      st              = mk(K_STATUS, carry, 64'd0, 8'd0);
      st.final_status = status;
      st.run_last     = 1'b1;
      if (en == 2'd0) e0 = st;
      else            e1 = st;
      en = en + 2'd1;

      phase_d = PH_TYPE;
      level_d = 8'd0;
      acc_d   = '0;
      minus_d = 1'b0;
      digit_d = 1'b0;
      brem_d  = '0;
      held_d  = 1'b0;
      fault_d = ST_OK;
    end else begin
      if (en == 2'd1) e0.run_last = 1'b1;
      if (en == 2'd2) e1.run_last = 1'b1;
    end

    push.cnt   = accept ? en : 2'd0;
    push.item0 = e0;
    push.item1 = e1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TYPE;
      level_q   <= '0;
      acc_q     <= '0;
      minus_q   <= 1'b0;
      digit_q   <= 1'b0;
      brem_q    <= '0;
      held_q    <= 1'b0;
      fault_q   <= ST_OK;
      top_cnt_q <= '0;
      top_fb_q  <= '0;
      load_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      level_q   <= level_d;
      acc_q     <= acc_d;
      minus_q   <= minus_d;
      digit_q   <= digit_d;
      brem_q    <= brem_d;
      held_q    <= held_d;
      fault_q   <= fault_d;
      top_cnt_q <= top_cnt_d;
      top_fb_q  <= top_fb_d;
      load_q    <= load_d;
    end
  end

`ifndef SYNTH
  // A stack reload never meets an array opening
  a_load_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_q |-> !wr_en) else $error("stack reload overlaps push");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= 8'(MAX_DEPTH)) else $error("nesting level beyond limit");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.data.end_of_reply) |=> (level_q == 8'd0 && fault_q == ST_OK
    && phase_q == PH_TYPE)) else $error("state not cleared after end item");

  a_fault_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_q != ST_OK) |-> (phase_q == PH_FAULT)) else $error("fault without fault phase");
`endif

endmodule

`default_nettype wire

// ----- test/rrp_checker.sv -----
// Token checker for the reply parser: watches both channels, predicts the
// tokens of every accepted reply byte and compares them. Depends on rrp_pkg, rrp_if.
`default_nettype none

module rrp_checker import rrp_pkg::*; #(
  parameter int MAX_DEPTH   = MaxDepthDef,
  parameter int LENGTH_BITS = LengthBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rrp_in_if.sink    in_i,
  rrp_out_if.sink   out_i,
  output int        fail_cnt_o,
  output int        tokens_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Parser state mirror
  phase_e      phase;
  logic [30:0] counts [0:MAX_DEPTH];
  logic [7:0]  level;
  logic [63:0] accum;
  logic        minus, digit, cr_held;
  logic [63:0] bulk_left;
  status_e     fault;
  bit          fault_set;

  out_item_t   tok_q[$];
  out_item_t   step_toks[$];

  assign tokens_due_o = tok_q.size();

  task automatic report(input string what, input out_item_t got, input out_item_t exp);
    fail_cnt_o++;
    $display("mismatch %s: got %h exp %h", what, got, exp);
  endtask

  function automatic void clear_state();
    phase = PH_TYPE; level = 0; accum = 0; minus = 0; digit = 0;
    cr_held = 0; bulk_left = 0; fault = ST_OK; fault_set = 0;
  endfunction

  function automatic void add_token(kind_e k, logic [7:0] pay, logic [63:0] val);
    out_item_t t;
    t = '0;
    t.token_kind = k; t.payload_byte = pay; t.int_value = val; t.nest_level_out = level;
    if (step_toks.size() < 3) step_toks.push_back(t);
  endfunction

  function automatic void raise(status_e c);
    if (!fault_set) begin
      fault = c;
      fault_set = 1;
    end
    phase = PH_FAULT;
    cr_held = 0;
  endfunction

  // Pop exhausted arrays after a complete value
  function automatic void value_done();
    int t;
    while (level > 0) begin
      t = level - 1;
      if (t > MAX_DEPTH) t = MAX_DEPTH;
      if (counts[t] > 1) begin
        counts[t]--;
        phase = PH_TYPE;
        return;
      end
      level--;
    end
    phase = PH_DONE;
  endfunction

  function automatic void open_number(phase_e p);
    accum = 0; minus = 0; digit = 0; cr_held = 0; phase = p;
  endfunction

  function automatic void close_number();
    logic        neg;
    logic [63:0] v;
    neg = minus && accum != 0;
    v = neg ? -accum : accum;
    if (!digit) begin
      raise(ST_BAD_LEN);
      return;
    end
    if (phase == PH_INT) begin
      add_token(K_INT, 0, v);
      value_done();
    end else if (phase == PH_BLEN) begin
      if (neg) begin
        if (accum == 1) begin
          add_token(K_NULL, 0, 0);
          value_done();
        end else raise(ST_BAD_BULK_LEN);
      end else if ((accum >> LENGTH_BITS) != 0) raise(ST_BAD_BULK_LEN);
      else begin
        bulk_left = accum;
        phase = (accum != 0) ? PH_BDATA : PH_BCR;
      end
    end else begin
      if (neg) begin
        if (accum == 1) begin
          add_token(K_NULL, 0, 0);
          value_done();
        end else raise(ST_BAD_ARR_LEN);
      end else if (accum > 64'h7fff_ffff) raise(ST_BAD_ARR_LEN);
      else begin
        add_token(K_ARRAY, 0, accum);
        if (accum == 0) value_done();
        else if (level >= MAX_DEPTH) raise(ST_INVALID);
        else begin
          counts[level] = accum[30:0];
          level++;
          phase = PH_TYPE;
        end
      end
    end
  endfunction

  function automatic void number_char(logic [7:0] b);
    logic [63:0] lim, nxt;
    if (cr_held) begin
      cr_held = 0;
      if (b == ChLf) begin
        close_number();
        return;
      end
      phase = PH_NUMBAD;
      cr_held = (b == ChCr);
      return;
    end
    if (b == ChCr) cr_held = 1;
    else if (b == ChMinus && !minus && !digit) minus = 1;
    else if (b >= ChZero && b <= ChNine) begin
      lim = minus ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      if (accum > 64'd922337203685477580) begin
        phase = PH_NUMBAD;
        return;
      end
      nxt = accum * 10 + 64'(b - ChZero);
      if (nxt > lim) begin
        phase = PH_NUMBAD;
        return;
      end
      accum = nxt;
      digit = 1;
    end else phase = PH_NUMBAD;
  endfunction

  function automatic void text_char(logic [7:0] b, kind_e k);
    if (cr_held) begin
      cr_held = 0;
      add_token(k, ChCr, 0);
    end
    if (b == ChCr) cr_held = 1;
    else add_token(k, b, 0);
  endfunction

  function automatic void parse_char(logic [7:0] b);
    case (phase)
      PH_TYPE: begin
        if (b == ChPlus) begin
          cr_held = 0;
          phase = PH_SIMPLE;
        end else if (b == ChColon) open_number(PH_INT);
        else if (b == ChDollar) open_number(PH_BLEN);
        else if (b == ChStar) open_number(PH_ALEN);
        else if (b == ChMinus && level == 0) begin
          cr_held = 0;
          phase = PH_ERRMSG;
        end else raise(ST_BAD_TYPE);
      end
      PH_SIMPLE: begin
        if (cr_held && b == ChLf) begin
          cr_held = 0;
          add_token(K_SIMPLE_END, 0, 0);
          value_done();
        end else text_char(b, K_TEXT);
      end
      PH_INT, PH_BLEN, PH_ALEN: number_char(b);
      PH_NUMBAD: begin
        if (cr_held && b == ChLf) raise(ST_BAD_LEN);
        else cr_held = (b == ChCr);
      end
      PH_BDATA: begin
        add_token(K_TEXT, b, 0);
        bulk_left--;
        if (bulk_left == 0) phase = PH_BCR;
      end
      PH_BCR: begin
        if (b == ChCr) phase = PH_BLF;
        else raise(ST_TRUNC_BULK);
      end
      PH_BLF: begin
        if (b == ChLf) begin
          add_token(K_BULK_END, 0, 0);
          value_done();
        end else raise(ST_TRUNC_BULK);
      end
      PH_ERRMSG: begin
        if (cr_held && b == ChLf) begin
          cr_held = 0;
          phase = PH_ERRDONE;
        end else text_char(b, K_ERR_BYTE);
      end
      PH_DONE: raise(ST_TRAILING);
      default: ;
    endcase
  endfunction

  function automatic status_e reply_status();
    if (fault_set) return fault;
    case (phase)
      PH_ERRMSG, PH_ERRDONE: return ST_ERR_REPLY;
      PH_DONE:               return ST_OK;
      PH_TYPE:               return ST_INVALID;
      PH_BDATA:              return ST_BAD_BULK_LEN;
      PH_BCR, PH_BLF:        return ST_TRUNC_BULK;
      default:               return ST_TRUNC_LINE;
    endcase
  endfunction

  // Predict the tokens of one accepted item and queue them
  function automatic void predict(in_item_t it);
    status_e    st;
    logic [7:0] carry;
    out_item_t  s;
    step_toks.delete();
    carry = 0;
    if (!it.no_byte) parse_char(it.byte_in);
    if (!it.end_of_reply) begin
      foreach (step_toks[i]) begin
        step_toks[i].run_last = (i == step_toks.size() - 1);
        tok_q.push_back(step_toks[i]);
      end
      return;
    end
    if (phase == PH_ERRMSG && cr_held) begin
      cr_held = 0;
      add_token(K_ERR_BYTE, ChCr, 0);
    end
    st = reply_status();
    if (st >= ST_INVALID) step_toks.delete();
    if (step_toks.size() > 1) begin
      carry = step_toks[1].payload_byte;
      tok_q.push_back(step_toks[0]);
    end else if (step_toks.size() == 1) tok_q.push_back(step_toks[0]);
    s = '0;
    s.token_kind = K_STATUS; s.payload_byte = carry; s.final_status = st; s.run_last = 1;
    tok_q.push_back(s);
    clear_state();
  endfunction

  // Watch both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e, g;
    if (!rst_ni) begin
      clear_state();
      tok_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        g = out_i.data;
        if (tok_q.size() == 0) report("unexpected token", g, '0);
        else begin
          e = tok_q.pop_front();
          if (g.token_kind !== e.token_kind) report("token_kind", g, e);
          else if (g.payload_byte !== e.payload_byte) report("payload_byte", g, e);
          else if (g.int_value !== e.int_value) report("int_value", g, e);
          else if (g.nest_level_out !== e.nest_level_out) report("nest_level", g, e);
          else if (g.final_status !== e.final_status) report("final_status", g, e);
          else if (g.run_last !== e.run_last) report("run_last", g, e);
        end
      end
      if (in_i.valid && in_i.ready) predict(in_i.data);
    end
  end
endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Top of the reply parser testbench: clock, reset, reply stimulus and verdict.
// Depends on rrp_pkg, rrp_if, rrp_checker and the resp_reply_parser RTL.
`default_nettype none

module tb;
  import rrp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 0;
  logic rst_ni = 0;
  int   fail_cnt, tokens_due;
  int   sent = 0;
  bit   calm = 0;
  bit   hold_long = 0;

  rrp_in_if  in_ch ();
  rrp_out_if out_ch ();

  resp_reply_parser u_dut (.clk_i, .rst_ni, .in_i(in_ch.sink), .out_o(out_ch.source));
  rrp_checker u_chk (.clk_i, .rst_ni, .in_i(in_ch.sink), .out_i(out_ch.sink),
                     .fail_cnt_o(fail_cnt), .tokens_due_o(tokens_due));

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  initial begin
    #2ms;
    $display("[resp_reply_parser] ERROR");
    $finish;
  end

  // Token receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    out_ch.ready = 0;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_ch.ready <= 0;
        repeat (300) @(negedge clk_i);
        hold_long = 0;
        out_ch.ready <= 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 17);
        out_ch.ready <= 0;
        repeat (n - 1) @(negedge clk_i);
      end else out_ch.ready <= 1;
    end
  end

  // Offer one item and hold it until accepted
  task automatic push_item(logic [7:0] b, logic nb, logic eor);
    int n;
    if (!calm && $urandom_range(0, 11) == 0) begin
      n = $urandom_range(1, 17);
      in_ch.valid <= 0;
      repeat (n) @(negedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.data <= '{byte_in: b, no_byte: nb, end_of_reply: eor};
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic push_text(string s);
    foreach (s[i]) push_item(s[i], 0, 0);
  endtask

  task automatic end_reply(logic [7:0] b, logic nb);
    push_item(b, nb, 1);
  endtask

  function automatic string rand_digits(int n);
    string s;
    s = "";
    repeat (n) s = {s, string'(8'($urandom_range(48, 57)))};
    return s;
  endfunction

  // Random well-formed value text, possibly nested
  function automatic string rand_value(int depth);
    string s;
    int    k, n;
    k = $urandom_range(0, depth < 3 ? 5 : 3);
    case (k)
      0: begin
        s = "+";
        repeat ($urandom_range(0, 5)) s = {s, string'(8'($urandom_range(32, 126)))};
        s = {s, "\r\n"};
      end
      1: s = {":", ($urandom_range(0, 1) ? "-" : ""), rand_digits($urandom_range(1, 19)), "\r\n"};
      2: begin
        n = $urandom_range(0, 5);
        s = $sformatf("$%0d\r\n", n);
        repeat (n) s = {s, string'(8'($urandom_range(0, 255)))};
        s = {s, "\r\n"};
      end
      3: s = ($urandom_range(0, 1)) ? "$-1\r\n" : "*-1\r\n";
      default: begin
        n = $urandom_range(0, 3);
        s = $sformatf("*%0d\r\n", n);
        repeat (n) s = {s, rand_value(depth + 1)};
      end
    endcase
    return s;
  endfunction

  task automatic wait_drain();
    in_ch.valid <= 0;
    while (tokens_due != 0) @(negedge clk_i);
  endtask

  initial begin
    string s;
    int    cut;
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed replies
    push_text("+OK\rx\r\n"); end_reply(0, 1);
    push_text(":-9223372036854775808\r\n"); end_reply(0, 1);
    push_text(":9223372036854775807\r"); end_reply(ChLf, 0);
    push_text(":9223372036854775808\r\n"); end_reply(0, 1);
    push_text("$3\r\n"); push_item(8'h00, 0, 0); push_item(8'hFF, 0, 0);
    push_item(8'h0D, 0, 0); push_text("\r\n"); end_reply(0, 1);
    push_text("$-1\r\n*-1\r\n"); end_reply(0, 1);
    push_text("$4294967296\r\n"); end_reply(0, 1);
    push_text("$-2\r\n"); end_reply(0, 1);
    push_text("*2147483648\r\n"); end_reply(0, 1);
    push_text("*2\r\n:1\r\n*0\r\n"); end_reply(0, 1);
    push_text("-ERR x\r"); end_reply(8'h79, 0);
    push_text("-E\r"); end_reply(0, 1);
    push_text("-E\r\nzz"); end_reply(0, 1);
    push_text("*1\r\n-E\r\n"); end_reply(0, 1);
    push_text("?"); end_reply(0, 1);
    end_reply(0, 1);
    push_text(":12"); end_reply(0, 1);
    push_text(":1-\r\n"); end_reply(0, 1);
    push_text(":\r\n"); end_reply(0, 1);
    push_text("$2\r\nab"); end_reply(0, 1);
    push_text("$2\r\na"); end_reply(0, 1);
    push_text("$1\r\naX"); end_reply(0, 1);
    push_text(":5\r\n"); push_item(0, 1, 0); end_reply(ChPlus, 0);
    // Nesting one level past the deepest allowed
    s = "";
    repeat (129) s = {s, "*1\r\n"};
    push_text(s); end_reply(0, 1);
    wait_drain();

    // Long receiver hold-off while bytes keep coming
    hold_long = 1;
    push_text("$40\r\n");
    repeat (40) push_item(8'($urandom_range(0, 255)), 0, 0);
    push_text("\r\n"); end_reply(0, 1);
    wait_drain();

    // Random replies: mostly well formed, some cut short or corrupted
    while (sent < 1900) begin
      if (sent > 1700) calm = 1;
      s = rand_value(0);
      cut = $urandom_range(0, 9);
      if (cut == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
      else if (cut == 1) s.putc($urandom_range(0, s.len() - 1), 8'($urandom_range(0, 255)));
      else if (cut == 2) s = {"-", rand_digits(3), "\r\nq"};
      if (s.len() > 1) push_text(s.substr(0, s.len() - 2));
      if ($urandom_range(0, 3) == 0) push_item(0, 1, 0);
      if ($urandom_range(0, 1)) end_reply(s[s.len() - 1], 0);
      else begin
        push_item(s[s.len() - 1], 0, 0);
        end_reply(8'($urandom_range(0, 255)), ($urandom_range(0, 3) != 0));
      end
    end

    wait_drain();
    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0 && tokens_due == 0) $display("[resp_reply_parser] OK");
    else $display("[resp_reply_parser] ERROR");
    $finish;
  end
endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/rrp_pkg.sv
hdl/rrp_if.sv
hdl/rrp_ram.sv
hdl/rrp_out_fifo.sv
hdl/resp_reply_parser.sv
test/rrp_checker.sv
test/tb.sv
